// ===== hw/rtl/gre_pkg.sv =====
// types, sizes and codes shared by the genome rearrangement engine
`timescale 1ns / 1ps
package gre_pkg;

  localparam int MAX_GENES  = 1024;
  localparam int ADDR_W     = $clog2(MAX_GENES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LABEL_BITS = 16;
  localparam int GAP_BITS   = 16;
  localparam int GENE_W     = LABEL_BITS + 1;
  localparam int POS_W      = 11;

  // command codes
  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_READ      = 3'd1;
  localparam logic [2:0] CMD_INSERT    = 3'd2;
  localparam logic [2:0] CMD_DELETE    = 3'd3;
  localparam logic [2:0] CMD_REVERSE   = 3'd4;
  localparam logic [2:0] CMD_TRANSPOSE = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_BAD_GAP = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [POS_W-1:0]        pos_first;
    logic [POS_W-1:0]        pos_second;
    logic [POS_W-1:0]        pos_third;
    logic [15:0]             gap_a;
    logic [15:0]             gap_b;
    logic [15:0]             gap_c;
    logic signed [15:0]      gene_label;
    logic                    deleted_mark;
    logic [15:0]             gap_value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [15:0]      read_label;
    logic                    read_mark;
    logic [15:0]             read_gap;
    logic [POS_W-1:0]        gene_count;
  } out_t;

endpackage

// ===== hw/rtl/genome_rearrangement_engine.sv =====
// genome rearrangement engine top level: command sequencer around gene and gap rams
// commands run one at a time; insert and delete move genes one by one through a copy stream,
// reverse swaps pairs in place, and transpose is done as three in-place reversals.
// each ram has a single write port and registered reads.
// reset (synchronous, rst_n low) empties the sequence; ram contents are not cleared.
`timescale 1ns / 1ps
module genome_rearrangement_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gre_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gre_pkg::out_t out_data
);

  localparam int AW = gre_pkg::ADDR_W;
  localparam int CW = gre_pkg::CNT_W;
  localparam int GW = gre_pkg::GAP_BITS;
  localparam int EW = gre_pkg::GENE_W;
  localparam int LW = gre_pkg::LABEL_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_F1    = 4'd2;
  localparam logic [3:0] S_F2    = 4'd3;
  localparam logic [3:0] S_F3    = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_SRD   = 4'd8;
  localparam logic [3:0] S_SWA   = 4'd9;
  localparam logic [3:0] S_SWB   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_READW = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, len_r, len_nxt;
  logic [GW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, gv_r, gv_nxt;
  logic [EW-1:0] newg_r, newg_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [15:0]   rl_r, rl_nxt, rg_r, rg_nxt;
  logic          rm_r, rm_nxt;
  logic [GW-1:0] g0_r, g0_nxt, g1_r, g1_nxt, g2_r, g2_nxt;
  logic [GW-1:0] b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [AW-1:0] s_r, s_nxt, dst_r, dst_nxt, pdst_r, pdst_nxt;
  logic          pend_r, pend_nxt, pgene_r, pgene_nxt, pgap_r, pgap_nxt;
  logic [CW-1:0] a_r, a_nxt, bg_r, bg_nxt, bp_r, bp_nxt;
  logic [1:0]    seg_r, seg_nxt, fin_r, fin_nxt;
  logic [EW-1:0] hgene_r, hgene_nxt;
  logic [GW-1:0] hgap_r, hgap_nxt;
  logic          out_valid_r, out_valid_nxt;
  gre_pkg::out_t out_r, out_nxt;

  // ram ports
  logic          gene_we, gap_we;
  logic [AW-1:0] gene_wa, gap_wa, gene_ra_a, gene_ra_b, gap_ra_a, gap_ra_b;
  logic [EW-1:0] gene_wd, gene_rd_a, gene_rd_b;
  logic [GW-1:0] gap_wd, gap_rd_a, gap_rd_b;

  gre_ram #(.W(EW), .AW(AW)) u_gene_ram (
    .clk(clk), .we(gene_we), .wa(gene_wa), .wd(gene_wd),
    .ra_a(gene_ra_a), .ra_b(gene_ra_b), .rd_a(gene_rd_a), .rd_b(gene_rd_b)
  );

  gre_ram #(.W(GW), .AW(AW)) u_gap_ram (
    .clk(clk), .we(gap_we), .wa(gap_wa), .wd(gap_wd),
    .ra_a(gap_ra_a), .ra_b(gap_ra_b), .rd_a(gap_rd_a), .rd_b(gap_rd_b)
  );

  // derived positions
  logic [CW-1:0] im1, im2, jm1, jm2, km2, ikj, lm1, dlen;
  assign im1  = i_r - CW'(1);
  assign im2  = i_r - CW'(2);
  assign jm1  = j_r - CW'(1);
  assign jm2  = j_r - CW'(2);
  assign km2  = k_r - CW'(2);
  assign ikj  = i_r + k_r - j_r - CW'(2);
  assign lm1  = len_r - CW'(1);
  assign dlen = j_r - i_r;

  // position checks
  logic pos_ok_ri, pos_ok_del, pos_ok_rev, pos_ok_trn, full;
  assign pos_ok_ri  = (i_r >= CW'(1)) && (i_r <= len_r);
  assign pos_ok_del = (i_r >= CW'(2)) && (i_r < j_r) && (j_r <= len_r);
  assign pos_ok_rev = (i_r >= CW'(2)) && (i_r <= j_r) && (j_r < len_r);
  assign pos_ok_trn = (i_r >= CW'(2)) && (i_r < j_r) && (j_r < k_r) && (k_r <= len_r);
  assign full       = (len_r >= CW'(gre_pkg::MAX_GENES));

  // gap split checks and recombined gaps
  logic [GW:0] sum_del, xr, yr, zr, rv0, rv1, tr0, tr1, tr2;
  logic        bad_del, bad_rev, bad_trn;
  assign sum_del = {1'b0, g0_r} + {1'b0, g1_r};
  assign xr      = {1'b0, g0_r} - {1'b0, x_r};
  assign yr      = {1'b0, g1_r} - {1'b0, y_r};
  assign zr      = {1'b0, g2_r} - {1'b0, z_r};
  assign rv0     = {1'b0, x_r} + {1'b0, y_r};
  assign rv1     = xr + yr;
  assign tr0     = {1'b0, x_r} + yr;
  assign tr1     = {1'b0, z_r} + xr;
  assign tr2     = {1'b0, y_r} + zr;
  assign bad_del = ({1'b0, x_r} > sum_del);
  assign bad_rev = (x_r > g0_r) || (y_r > g1_r) || rv0[GW] || rv1[GW];
  assign bad_trn = (x_r > g0_r) || (y_r > g1_r) || (z_r > g2_r)
                   || tr0[GW] || tr1[GW] || tr2[GW];

  // swap activity
  logic gene_act, gap_act;
  assign gene_act = (a_r < bg_r);
  assign gap_act  = (a_r < bp_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;   cmd_nxt = cmd_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; len_nxt = len_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; gv_nxt = gv_r; newg_nxt = newg_r;
    status_nxt = status_r; rl_nxt = rl_r; rm_nxt = rm_r; rg_nxt = rg_r;
    g0_nxt = g0_r; g1_nxt = g1_r; g2_nxt = g2_r;
    b0_nxt = b0_r; b1_nxt = b1_r; b2_nxt = b2_r;
    s_nxt = s_r; dst_nxt = dst_r; pdst_nxt = pdst_r;
    pend_nxt = pend_r; pgene_nxt = pgene_r; pgap_nxt = pgap_r;
    a_nxt = a_r; bg_nxt = bg_r; bp_nxt = bp_r; seg_nxt = seg_r; fin_nxt = fin_r;
    hgene_nxt = hgene_r; hgap_nxt = hgap_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;

    gene_we = 1'b0; gene_wa = '0; gene_wd = newg_r;
    gap_we  = 1'b0; gap_wa  = '0; gap_wd  = gv_r;
    gene_ra_a = im1[AW-1:0]; gene_ra_b = bg_r[AW-1:0];
    gap_ra_a  = im1[AW-1:0]; gap_ra_b  = bp_r[AW-1:0];

    // output register drain
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // pending copy write from the shift stream
    if (pend_r) begin
      gene_we = pgene_r; gene_wa = pdst_r; gene_wd = gene_rd_a;
      gap_we  = pgap_r;  gap_wa  = pdst_r; gap_wd  = gap_rd_a;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data.cmd;
          i_nxt      = in_data.pos_first;
          j_nxt      = in_data.pos_second;
          k_nxt      = in_data.pos_third;
          x_nxt      = in_data.gap_a;
          y_nxt      = in_data.gap_b;
          z_nxt      = in_data.gap_c;
          gv_nxt     = in_data.gap_value;
          newg_nxt   = {in_data.deleted_mark, in_data.gene_label[LW-1:0]};
          status_nxt = gre_pkg::ST_OK;
          rl_nxt     = '0;
          rm_nxt     = 1'b0;
          rg_nxt     = '0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          gre_pkg::CMD_APPEND: begin
            if (full) begin
              status_nxt = gre_pkg::ST_FULL;
            end else begin
              gene_we = 1'b1; gene_wa = len_r[AW-1:0]; gene_wd = newg_r;
              gap_we  = (len_r != '0); gap_wa = lm1[AW-1:0]; gap_wd = gv_r;
              len_nxt = len_r + CW'(1);
            end
          end
          gre_pkg::CMD_READ: begin
            if (!pos_ok_ri) begin
              status_nxt = gre_pkg::ST_BAD_POS;
            end else begin
              state_nxt = S_READW;
            end
          end
          gre_pkg::CMD_INSERT: begin
            if (!pos_ok_ri) begin
              status_nxt = gre_pkg::ST_BAD_POS;
            end else if (full) begin
              status_nxt = gre_pkg::ST_FULL;
            end else begin
              s_nxt     = lm1[AW-1:0];
              dst_nxt   = len_r[AW-1:0];
              state_nxt = S_SHIFT;
            end
          end
          gre_pkg::CMD_DELETE: begin
            if (!pos_ok_del) status_nxt = gre_pkg::ST_BAD_POS;
            else state_nxt = S_F1;
          end
          gre_pkg::CMD_REVERSE: begin
            if (!pos_ok_rev) status_nxt = gre_pkg::ST_BAD_POS;
            else state_nxt = S_F1;
          end
          gre_pkg::CMD_TRANSPOSE: begin
            if (!pos_ok_trn) status_nxt = gre_pkg::ST_BAD_POS;
            else state_nxt = S_F1;
          end
          default: begin
            status_nxt = gre_pkg::ST_OK;
          end
        endcase
      end

      // fetch the boundary gaps
      S_F1: begin
        gap_ra_a  = im2[AW-1:0];
        gap_ra_b  = (cmd_r == gre_pkg::CMD_REVERSE) ? jm1[AW-1:0] : jm2[AW-1:0];
        state_nxt = S_F2;
      end

      S_F2: begin
        g0_nxt    = gap_rd_a;
        g1_nxt    = gap_rd_b;
        gap_ra_a  = km2[AW-1:0];
        state_nxt = S_F3;
      end

      S_F3: begin
        g2_nxt    = gap_rd_a;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        state_nxt = S_DONE;
        seg_nxt   = 2'd0;
        fin_nxt   = 2'd0;
        if (cmd_r == gre_pkg::CMD_DELETE) begin
          if (bad_del) begin
            status_nxt = gre_pkg::ST_BAD_GAP;
          end else begin
            s_nxt     = jm1[AW-1:0];
            dst_nxt   = im1[AW-1:0];
            state_nxt = S_SHIFT;
          end
        end else if (cmd_r == gre_pkg::CMD_REVERSE) begin
          if (bad_rev) begin
            status_nxt = gre_pkg::ST_BAD_GAP;
          end else begin
            b0_nxt    = rv0[GW-1:0];
            b1_nxt    = rv1[GW-1:0];
            a_nxt     = im1;
            bg_nxt    = jm1;
            bp_nxt    = jm2;
            state_nxt = S_SRD;
          end
        end else begin
          if (bad_trn) begin
            status_nxt = gre_pkg::ST_BAD_GAP;
          end else begin
            b0_nxt    = tr0[GW-1:0];
            b1_nxt    = tr1[GW-1:0];
            b2_nxt    = tr2[GW-1:0];
            a_nxt     = im1;
            bg_nxt    = jm2;
            bp_nxt    = jm2;
            state_nxt = S_SRD;
          end
        end
      end

      // copy stream: read at s, write in the following cycle at the destination
      S_SHIFT: begin
        gene_ra_a = s_r;
        gap_ra_a  = s_r;
        pend_nxt  = 1'b1;
        pdst_nxt  = dst_r;
        pgap_nxt  = (({1'b0, s_r} + CW'(1)) < len_r);
        if (cmd_r == gre_pkg::CMD_INSERT) begin
          pgene_nxt = ({1'b0, s_r} >= i_r);
          s_nxt     = s_r - AW'(1);
          dst_nxt   = dst_r - AW'(1);
          if ({1'b0, s_r} == im1) state_nxt = S_DRAIN;
        end else begin
          pgene_nxt = 1'b1;
          s_nxt     = s_r + AW'(1);
          dst_nxt   = dst_r + AW'(1);
          if ({1'b0, s_r} == lm1) state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        pend_nxt  = 1'b0;
        state_nxt = S_FIN;
      end

      // swap loop of one in-place reversal
      S_SRD: begin
        gene_ra_a = a_r[AW-1:0];
        gene_ra_b = bg_r[AW-1:0];
        gap_ra_a  = a_r[AW-1:0];
        gap_ra_b  = bp_r[AW-1:0];
        if (gene_act || gap_act) begin
          state_nxt = S_SWA;
        end else if (cmd_r == gre_pkg::CMD_TRANSPOSE && seg_r == 2'd0) begin
          seg_nxt = 2'd1;
          a_nxt   = jm1;
          bg_nxt  = km2;
          bp_nxt  = km2;
        end else if (cmd_r == gre_pkg::CMD_TRANSPOSE && seg_r == 2'd1) begin
          seg_nxt = 2'd2;
          a_nxt   = im1;
          bg_nxt  = km2;
          bp_nxt  = km2;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SWA: begin
        gene_we   = gene_act; gene_wa = a_r[AW-1:0]; gene_wd = gene_rd_b;
        gap_we    = gap_act;  gap_wa  = a_r[AW-1:0]; gap_wd  = gap_rd_b;
        hgene_nxt = gene_rd_a;
        hgap_nxt  = gap_rd_a;
        state_nxt = S_SWB;
      end

      S_SWB: begin
        gene_we   = gene_act; gene_wa = bg_r[AW-1:0]; gene_wd = hgene_r;
        gap_we    = gap_act;  gap_wa  = bp_r[AW-1:0]; gap_wd  = hgap_r;
        a_nxt     = a_r + CW'(1);
        if (gene_act) bg_nxt = bg_r - CW'(1);
        if (gap_act) bp_nxt = bp_r - CW'(1);
        state_nxt = S_SRD;
      end

      // final boundary writes
      S_FIN: begin
        fin_nxt   = fin_r + 2'd1;
        state_nxt = S_DONE;
        gap_we    = 1'b1;
        case (cmd_r)
          gre_pkg::CMD_INSERT: begin
            gene_we = 1'b1; gene_wa = i_r[AW-1:0]; gene_wd = newg_r;
            gap_wa  = im1[AW-1:0]; gap_wd = gv_r;
            len_nxt = len_r + CW'(1);
          end
          gre_pkg::CMD_DELETE: begin
            gap_wa  = im2[AW-1:0]; gap_wd = x_r;
            len_nxt = len_r - dlen;
          end
          gre_pkg::CMD_REVERSE: begin
            if (fin_r == 2'd0) begin
              gap_wa    = im2[AW-1:0]; gap_wd = b0_r;
              state_nxt = S_FIN;
            end else begin
              gap_wa = jm1[AW-1:0]; gap_wd = b1_r;
            end
          end
          default: begin
            if (fin_r == 2'd0) begin
              gap_wa    = im2[AW-1:0]; gap_wd = b0_r;
              state_nxt = S_FIN;
            end else if (fin_r == 2'd1) begin
              gap_wa    = ikj[AW-1:0]; gap_wd = b1_r;
              state_nxt = S_FIN;
            end else begin
              gap_wa = km2[AW-1:0]; gap_wd = b2_r;
            end
          end
        endcase
      end

      S_READW: begin
        rl_nxt    = 16'(signed'(gene_rd_a[LW-1:0]));
        rm_nxt    = gene_rd_a[EW-1];
        rg_nxt    = (i_r < len_r) ? 16'(gap_rd_a) : 16'd0;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = status_r;
          out_nxt.read_label    = rl_r;
          out_nxt.read_mark     = rm_r;
          out_nxt.read_gap      = rg_r;
          out_nxt.gene_count    = len_r;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;
    x_r <= x_nxt;  y_r <= y_nxt;  z_r <= z_nxt;  gv_r <= gv_nxt;  newg_r <= newg_nxt;
    status_r <= status_nxt;  rl_r <= rl_nxt;  rm_r <= rm_nxt;  rg_r <= rg_nxt;
    g0_r <= g0_nxt;  g1_r <= g1_nxt;  g2_r <= g2_nxt;
    b0_r <= b0_nxt;  b1_r <= b1_nxt;  b2_r <= b2_nxt;
    s_r <= s_nxt;  dst_r <= dst_nxt;  pdst_r <= pdst_nxt;
    pgene_r <= pgene_nxt;  pgap_r <= pgap_nxt;
    a_r <= a_nxt;  bg_r <= bg_nxt;  bp_r <= bp_nxt;  seg_r <= seg_nxt;  fin_r <= fin_nxt;
    hgene_r <= hgene_nxt;  hgap_r <= hgap_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== hw/rtl/gre_ram.sv =====
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps
module gre_ram #(
  parameter int W  = 16,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic [AW-1:0] ra_a,
  input  logic [AW-1:0] ra_b,
  output logic [W-1:0]  rd_a,
  output logic [W-1:0]  rd_b
);

  logic [W-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the genome rearrangement engine
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 5000000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  gre_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall = 1'b0;
  gre_pkg::out_t out_data;

  int sender_idle_pct;
  int receiver_stall_pct;
  int cycle_count = 0;

  genome_rearrangement_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // gene sequence predictor and store of expected results
  class gre_scoreboard;
    logic signed [15:0] labels[gre_pkg::MAX_GENES];
    logic               marks[gre_pkg::MAX_GENES];
    logic [15:0]        gaps[gre_pkg::MAX_GENES];
    logic signed [15:0] hold_label[gre_pkg::MAX_GENES];
    logic               hold_mark[gre_pkg::MAX_GENES];
    logic [15:0]        hold_gap[gre_pkg::MAX_GENES];
    int                 count;
    gre_pkg::out_t      awaited[$];
    int                 mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    // apply one accepted command and queue its result
    function void note_input(gre_pkg::in_t d);
      gre_pkg::out_t res;
      int i, j, k, x, y, z, xr, yr, zr, t, r, a, b, n;
      logic signed [15:0] sl;
      logic sm;
      logic [15:0] sg;
      res = '0;
      res.status = gre_pkg::ST_OK;
      i = int'(d.pos_first);
      j = int'(d.pos_second);
      k = int'(d.pos_third);
      x = int'(d.gap_a);
      y = int'(d.gap_b);
      z = int'(d.gap_c);
      case (d.cmd)
        gre_pkg::CMD_APPEND: begin
          if (count >= gre_pkg::MAX_GENES) res.status = gre_pkg::ST_FULL;
          else begin
            labels[count] = d.gene_label;
            marks[count] = d.deleted_mark;
            if (count > 0) gaps[count-1] = d.gap_value;
            count++;
          end
        end
        gre_pkg::CMD_READ: begin
          if (i < 1 || i > count) res.status = gre_pkg::ST_BAD_POS;
          else begin
            res.read_label = labels[i-1];
            res.read_mark = marks[i-1];
            res.read_gap = (i < count) ? gaps[i-1] : 16'd0;
          end
        end
        gre_pkg::CMD_INSERT: begin
          if (i < 1 || i > count) res.status = gre_pkg::ST_BAD_POS;
          else if (count >= gre_pkg::MAX_GENES) res.status = gre_pkg::ST_FULL;
          else begin
            for (t = count; t > i; t--) begin
              labels[t] = labels[t-1];
              marks[t] = marks[t-1];
            end
            for (t = count - 1; t > i - 1; t--) gaps[t] = gaps[t-1];
            labels[i] = d.gene_label;
            marks[i] = d.deleted_mark;
            gaps[i-1] = d.gap_value;
            count++;
          end
        end
        gre_pkg::CMD_DELETE: begin
          if (i < 2 || i >= j || j > count) res.status = gre_pkg::ST_BAD_POS;
          else if (x > int'(gaps[i-2]) + int'(gaps[j-2])) res.status = gre_pkg::ST_BAD_GAP;
          else begin
            gaps[i-2] = 16'(x);
            t = i - 1;
            for (r = j - 1; r < count; r++) begin
              labels[t] = labels[r];
              marks[t] = marks[r];
              if (r + 1 < count) gaps[t] = gaps[r];
              t++;
            end
            count -= (j - i);
          end
        end
        gre_pkg::CMD_REVERSE: begin
          if (i < 2 || i > j || j >= count) res.status = gre_pkg::ST_BAD_POS;
          else if (x > int'(gaps[i-2]) || y > int'(gaps[j-1]))
            res.status = gre_pkg::ST_BAD_GAP;
          else begin
            xr = int'(gaps[i-2]) - x;
            yr = int'(gaps[j-1]) - y;
            if (x + y > 65535 || xr + yr > 65535) res.status = gre_pkg::ST_BAD_GAP;
            else begin
              a = i - 1;
              b = j - 1;
              while (a < b) begin
                sl = labels[a]; sm = marks[a];
                labels[a] = labels[b]; marks[a] = marks[b];
                labels[b] = sl; marks[b] = sm;
                a++; b--;
              end
              a = i - 1;
              b = j - 2;
              while (a < b) begin
                sg = gaps[a]; gaps[a] = gaps[b]; gaps[b] = sg;
                a++; b--;
              end
              gaps[i-2] = 16'(x + y);
              gaps[j-1] = 16'(xr + yr);
            end
          end
        end
        gre_pkg::CMD_TRANSPOSE: begin
          if (i < 2 || i >= j || j >= k || k > count) res.status = gre_pkg::ST_BAD_POS;
          else if (x > int'(gaps[i-2]) || y > int'(gaps[j-2]) || z > int'(gaps[k-2]))
            res.status = gre_pkg::ST_BAD_GAP;
          else begin
            xr = int'(gaps[i-2]) - x;
            yr = int'(gaps[j-2]) - y;
            zr = int'(gaps[k-2]) - z;
            if (x + yr > 65535 || z + xr > 65535 || y + zr > 65535)
              res.status = gre_pkg::ST_BAD_GAP;
            else begin
              n = 0;
              for (r = i - 1; r <= j - 2; r++) begin
                hold_label[n] = labels[r]; hold_mark[n] = marks[r]; hold_gap[n] = gaps[r];
                n++;
              end
              t = i - 1;
              for (r = j - 1; r <= k - 2; r++) begin
                labels[t] = labels[r]; marks[t] = marks[r]; gaps[t] = gaps[r];
                t++;
              end
              for (r = 0; r < n; r++) begin
                labels[t] = hold_label[r]; marks[t] = hold_mark[r]; gaps[t] = hold_gap[r];
                t++;
              end
              gaps[i-2] = 16'(x + yr);
              gaps[i+k-j-2] = 16'(z + xr);
              gaps[k-2] = 16'(y + zr);
            end
          end
        end
        default: ;
      endcase
      res.gene_count = 11'(count);
      awaited.insert(awaited.size(), res);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(gre_pkg::out_t got);
      gre_pkg::out_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.read_label !== want.read_label ||
          got.read_mark !== want.read_mark || got.read_gap !== want.read_gap ||
          got.gene_count !== want.gene_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st=%0d lab=%0d mk=%0d gap=%0d cnt=%0d,",
                   want.status, want.read_label, want.read_mark, want.read_gap,
                   want.gene_count, " got st=%0d lab=%0d mk=%0d gap=%0d cnt=%0d",
                   got.status, got.read_label, got.read_mark,
                   got.read_gap, got.gene_count);
      end
    endfunction
  endclass

  gre_scoreboard sb = new();

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic gre_pkg::in_t make_cmd(logic [2:0] c, int i, int j, int k, int x,
                                            int y, int z, int lab, bit mk, int gv);
    gre_pkg::in_t d;
    d.cmd = c;
    d.pos_first = 11'(i);
    d.pos_second = 11'(j);
    d.pos_third = 11'(k);
    d.gap_a = 16'(x);
    d.gap_b = 16'(y);
    d.gap_c = 16'(z);
    d.gene_label = 16'(lab);
    d.deleted_mark = mk;
    d.gap_value = 16'(gv);
    return d;
  endfunction

  // present one command and hold it until the transfer happens
  task automatic send(gre_pkg::in_t d);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    sb.note_input(d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic int bounded(int limit);
    if ($urandom_range(0, 9) == 0) return limit + 1;
    return $urandom_range(0, limit);
  endfunction

  function automatic int gap_pick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 200);
    if (r < 9) return $urandom_range(0, 65535);
    return 65535;
  endfunction

  // mostly well-formed commands at valid positions, some noise
  function automatic gre_pkg::in_t random_cmd();
    gre_pkg::in_t d;
    int len, r, i, j, k;
    d = make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, $urandom_range(0, 65535),
                 1'($urandom_range(0, 1)), gap_pick());
    if ($urandom_range(0, 9) == 0) begin
      d.cmd = 3'($urandom_range(0, 7));
      d.pos_first = 11'($urandom_range(0, 2047));
      d.pos_second = 11'($urandom_range(0, 2047));
      d.pos_third = 11'($urandom_range(0, 2047));
      d.gap_a = 16'($urandom_range(0, 65535));
      d.gap_b = 16'($urandom_range(0, 65535));
      d.gap_c = 16'($urandom_range(0, 65535));
      return d;
    end
    len = sb.count;
    r = $urandom_range(0, 99);
    if (len < 6) r = r % 30;
    else if (len > 48 && r < 30) r = r + 40;
    if (r < 15) return d;
    if (r < 30) begin
      d.cmd = gre_pkg::CMD_INSERT;
      d.pos_first = 11'((len > 0) ? $urandom_range(1, len) : 1);
      return d;
    end
    if (r < 45) begin
      d.cmd = gre_pkg::CMD_READ;
      d.pos_first = 11'($urandom_range(1, len));
      return d;
    end
    if (r < 65) begin
      d.cmd = gre_pkg::CMD_DELETE;
      i = $urandom_range(2, len - 1);
      j = $urandom_range(i + 1, (i + 8 < len) ? i + 8 : len);
      d.pos_first = 11'(i);
      d.pos_second = 11'(j);
      k = int'(sb.gaps[i-2]) + int'(sb.gaps[j-2]);
      d.gap_a = 16'((k > 65535) ? $urandom_range(0, 65535) : bounded(k));
      return d;
    end
    if (r < 82) begin
      d.cmd = gre_pkg::CMD_REVERSE;
      i = $urandom_range(2, len - 1);
      j = $urandom_range(i, (i + 15 < len - 1) ? i + 15 : len - 1);
      d.pos_first = 11'(i);
      d.pos_second = 11'(j);
      d.gap_a = 16'(bounded(int'(sb.gaps[i-2])));
      d.gap_b = 16'(bounded(int'(sb.gaps[j-1])));
      return d;
    end
    d.cmd = gre_pkg::CMD_TRANSPOSE;
    i = $urandom_range(2, len - 2);
    j = $urandom_range(i + 1, (i + 8 < len - 1) ? i + 8 : len - 1);
    k = $urandom_range(j + 1, (j + 8 < len) ? j + 8 : len);
    d.pos_first = 11'(i);
    d.pos_second = 11'(j);
    d.pos_third = 11'(k);
    d.gap_a = 16'(bounded(int'(sb.gaps[i-2])));
    d.gap_b = 16'(bounded(int'(sb.gaps[j-2])));
    d.gap_c = 16'(bounded(int'(sb.gaps[k-2])));
    return d;
  endfunction

  initial begin
    int phase, n, g;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, each command, position and gap error paths
    send(make_cmd(gre_pkg::CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_DELETE, 2, 3, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_INSERT, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, -32768, 1, 12345));
    send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, 32767, 0, 65535));
    send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, -1, 0, 1000));
    send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, 5, 1, 1000));
    send(make_cmd(gre_pkg::CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_READ, 6, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_READ, 2047, 2047, 2047, 65535, 65535, 65535, -1, 1, 65535));
    send(make_cmd(gre_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 7, 0, 3));
    send(make_cmd(gre_pkg::CMD_INSERT, 6, 0, 0, 0, 0, 0, 9, 1, 77));
    send(make_cmd(gre_pkg::CMD_INSERT, 1, 0, 0, 0, 0, 0, -9, 0, 500));
    send(make_cmd(gre_pkg::CMD_REVERSE, 3, 3, 0, 65535, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_REVERSE, 3, 7, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_REVERSE, 2, 4, 0, 65535, 40000, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_REVERSE, 2, 5, 0, 100, 200, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_TRANSPOSE, 2, 4, 6, 10, 0, 5, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_TRANSPOSE, 2, 2, 6, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_TRANSPOSE, 2, 3, 7, 65535, 65535, 65535, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_DELETE, 2, 4, 0, 65535, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_DELETE, 3, 5, 0, 1, 0, 0, 0, 0, 0));
    send(make_cmd(3'd6, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    send(make_cmd(3'd7, 2, 3, 4, 5, 6, 7, 8, 0, 9));

    // random commands over the idling settings
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      for (n = 0; n < 40; n++) begin
        if (n == 20) drain();
        send(random_cmd());
      end
    end

    // fill to capacity, check full store, then cut back
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    while (sb.count < gre_pkg::MAX_GENES - 1)
      send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, $urandom_range(0, 65535),
                    1'($urandom_range(0, 1)), $urandom_range(0, 65535)));
    send(make_cmd(gre_pkg::CMD_INSERT, 1, 0, 0, 0, 0, 0, 321, 1, 42));
    send(make_cmd(gre_pkg::CMD_APPEND, 0, 0, 0, 0, 0, 0, 1, 0, 1));
    send(make_cmd(gre_pkg::CMD_INSERT, 1024, 0, 0, 0, 0, 0, 2, 1, 2));
    send(make_cmd(gre_pkg::CMD_READ, 1024, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_READ, 1025, 0, 0, 0, 0, 0, 0, 0, 0));
    g = int'(sb.gaps[0]) + int'(sb.gaps[1022]);
    send(make_cmd(gre_pkg::CMD_DELETE, 2, 1024, 0, (g > 65535) ? 65535 : g, 0, 0, 0, 0, 0));
    send(make_cmd(gre_pkg::CMD_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));

    // wait for outstanding results, then a short quiet tail
    drain();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/gre_pkg.sv
hw/rtl/gre_ram.sv
hw/rtl/genome_rearrangement_engine.sv
verif/tb.sv
